// ----- sv/ecgdf_pkg.sv -----
// Shared constants, types and address decode for the ECG frame word deframer.
`default_nettype none

package ecgdf_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned PayloadW = 24;
  localparam int unsigned CountW = 4;

  // parse phase codes
  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_BUSY = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // event kinds
  localparam logic [2:0] EV_START   = 3'd0;
  localparam logic [2:0] EV_FIELD   = 3'd1;
  localparam logic [2:0] EV_FAULT   = 3'd2;
  localparam logic [2:0] EV_LOST    = 3'd3;
  localparam logic [2:0] EV_UNKNOWN = 3'd4;

  // register indexes
  localparam logic [1:0] REG_WORDS = 2'd0;
  localparam logic [1:0] REG_MASK  = 2'd1;
  localparam logic [1:0] REG_MATCH = 2'd2;

  localparam logic [CountW-1:0] WORDS_RESET = 4'd11;
  localparam logic [WordW-1:0] MASK_RESET = 32'h0000_0000;
  localparam logic [WordW-1:0] MATCH_RESET = 32'h0000_0001;

  typedef struct packed {
    logic [CountW-1:0] frame_words;
    logic [WordW-1:0]  fault_mask;
    logic [WordW-1:0]  fault_match;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [CountW-1:0] words_left;
  } parse_state_t;

  typedef struct packed {
    logic                present;
    logic [2:0]          event_kind;
    logic [3:0]          field_id;
    logic [PayloadW-1:0] raw_payload;
    logic [1:0]          dropped_count;
    logic                last_of_frame;
  } result_t;

  typedef struct packed {
    logic       known;
    logic [3:0] id;
  } field_map_t;

  function automatic field_map_t map_address(input logic [7:0] addr);
    field_map_t m;
    m.known = 1'b1;
    case (addr)
      8'h11: m.id = 4'd0;
      8'h12: m.id = 4'd1;
      8'h13: m.id = 4'd2;
      8'h14: m.id = 4'd3;
      8'h15: m.id = 4'd4;
      8'h1A: m.id = 4'd5;
      8'h1B: m.id = 4'd6;
      8'h1C: m.id = 4'd7;
      8'h1D: m.id = 4'd8;
      8'h06: m.id = 4'd9;
      8'h41: m.id = 4'd10;
      default: begin
        m.known = 1'b0;
        m.id = 4'd0;
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ecg_frame_word_deframer.sv -----
// Top level of the ECG frame word deframer: input register, parse state, result register, APB.
//
// Input channel data_valid/data_ready carries one 32-bit stream word in data_word.
// Output channel event_valid/event_ready carries one event per result word:
// event_kind, field_id, raw_payload, signed_sample, dropped_count, last_of_frame.
// Words that yield no event (idle words while seeking a header, busy headers) are consumed silently.
// An event passes through the input register and then the result register before event_valid rises.
// Throughput: one word per cycle unless the output stalls; the input register and result register
// let a new word enter while a finished event waits to be taken.
// When event_ready is low, the result register holds, the input register fills,
// and data_ready drops only once both are occupied (words without an event
// still pass through the input register).
// Registers on APB: 0x0 frame length in data words, 0x4 fault_mask, 0x8 fault_match.
// Write them only while no word is in flight.
// Reset (rst, synchronous) empties both registers, seeks a header and
// restores frame length 11, fault_mask 0, fault_match 1.
`default_nettype none

module ecg_frame_word_deframer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                data_valid,
  output logic                                     data_ready,
  input  wire logic [ecgdf_pkg::WordW-1:0]         data_word,
  output logic                                     event_valid,
  input  wire logic                                event_ready,
  output logic [2:0]                               event_kind,
  output logic [3:0]                               field_id,
  output logic [ecgdf_pkg::PayloadW-1:0]           raw_payload,
  output logic signed [ecgdf_pkg::PayloadW-1:0]    signed_sample,
  output logic [1:0]                               dropped_count,
  output logic                                     last_of_frame,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [3:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  ecgdf_pkg::cfg_t           cfg;
  ecgdf_pkg::parse_state_t   state;
  ecgdf_pkg::parse_state_t   state_next;
  ecgdf_pkg::result_t        result;
  logic                      hold_valid;
  logic [ecgdf_pkg::WordW-1:0] hold_word;
  logic                      hold_fire;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_words <= ecgdf_pkg::WORDS_RESET;
      cfg.fault_mask <= ecgdf_pkg::MASK_RESET;
      cfg.fault_match <= ecgdf_pkg::MATCH_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        ecgdf_pkg::REG_WORDS: cfg.frame_words <= pwdata[ecgdf_pkg::CountW-1:0];
        ecgdf_pkg::REG_MASK:  cfg.fault_mask <= pwdata;
        ecgdf_pkg::REG_MATCH: cfg.fault_match <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ecgdf_pkg::REG_WORDS: prdata = {28'd0, cfg.frame_words};
      ecgdf_pkg::REG_MASK:  prdata = cfg.fault_mask;
      ecgdf_pkg::REG_MATCH: prdata = cfg.fault_match;
      default:              prdata = '0;
    endcase
  end

  ecgdf_step u_step (
    .word       (hold_word),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  assign hold_fire  = hold_valid & (~result.present | ~event_valid | event_ready);
  assign data_ready = ~hold_valid | hold_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (data_ready) begin
      hold_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      hold_word <= data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= ecgdf_pkg::PH_SEEK;
      state.words_left <= '0;
    end else if (hold_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (hold_fire && result.present) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire && result.present) begin
      event_kind <= result.event_kind;
      field_id <= result.field_id;
      raw_payload <= result.raw_payload;
      signed_sample <= result.raw_payload;
      dropped_count <= result.dropped_count;
      last_of_frame <= result.last_of_frame;
    end
  end

  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    state.phase == ecgdf_pkg::PH_DATA |-> state.words_left != '0)
    else $error("data phase with no words left");

  a_open_frame_kind: assert property (@(posedge clk) disable iff (rst)
    event_valid && !last_of_frame |->
      event_kind == ecgdf_pkg::EV_START || event_kind == ecgdf_pkg::EV_FIELD ||
      event_kind == ecgdf_pkg::EV_UNKNOWN)
    else $error("error event without last_of_frame");

  a_dropped_on_start: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind != ecgdf_pkg::EV_START |-> dropped_count == 2'd0)
    else $error("dropped count outside frame start");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !hold_fire |=> hold_valid && $stable(hold_word))
    else $error("input register lost a word");

endmodule

`default_nettype wire

// ----- sv/ecgdf_step.sv -----
// Per-word parse step: header/busy/fault decode, field demux and next parse state.
`default_nettype none

module ecgdf_step (
  input  wire logic [ecgdf_pkg::WordW-1:0] word,
  input  wire ecgdf_pkg::cfg_t             cfg,
  input  wire ecgdf_pkg::parse_state_t     state,
  output ecgdf_pkg::parse_state_t          state_next,
  output ecgdf_pkg::result_t               result
);

  logic                          hdr_bit;
  logic                          is_busy;
  logic                          is_fault;
  logic [ecgdf_pkg::CountW-1:0]  left_dec;
  ecgdf_pkg::field_map_t         fmap;
  ecgdf_pkg::parse_state_t       hdr_state;
  ecgdf_pkg::result_t            hdr_result;
  ecgdf_pkg::result_t            none;

  assign hdr_bit   = word[31];
  assign is_busy   = word[31] & word[30];
  assign is_fault  = (word & cfg.fault_mask) == cfg.fault_match;
  assign left_dec  = state.words_left - 1'b1;
  assign fmap      = ecgdf_pkg::map_address(word[31:24]);

  always_comb begin
    none = '0;
    hdr_result = '0;
    hdr_result.present = 1'b1;
    hdr_result.last_of_frame = 1'b1;
    if (is_fault) begin
      hdr_state.phase = ecgdf_pkg::PH_SEEK;
      hdr_state.words_left = '0;
      hdr_result.event_kind = ecgdf_pkg::EV_FAULT;
    end else begin
      hdr_state.words_left = cfg.frame_words;
      hdr_result.event_kind = ecgdf_pkg::EV_START;
      hdr_result.dropped_count = word[29:28];
      if (cfg.frame_words == '0) begin
        hdr_state.phase = ecgdf_pkg::PH_SEEK;
      end else begin
        hdr_state.phase = ecgdf_pkg::PH_DATA;
        hdr_result.last_of_frame = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    result = none;
    case (state.phase)
      ecgdf_pkg::PH_DATA: begin
        state_next.words_left = left_dec;
        state_next.phase = (left_dec == '0) ? ecgdf_pkg::PH_SEEK : ecgdf_pkg::PH_DATA;
        result.present = 1'b1;
        result.event_kind = fmap.known ? ecgdf_pkg::EV_FIELD : ecgdf_pkg::EV_UNKNOWN;
        result.field_id = fmap.id;
        result.raw_payload = word[ecgdf_pkg::PayloadW-1:0];
        result.last_of_frame = (left_dec == '0);
      end
      ecgdf_pkg::PH_BUSY: begin
        if (is_busy) begin
          state_next = state;
        end else if (hdr_bit) begin
          state_next = hdr_state;
          result = hdr_result;
        end else begin
          state_next.phase = ecgdf_pkg::PH_SEEK;
          result.present = 1'b1;
          result.event_kind = ecgdf_pkg::EV_LOST;
          result.last_of_frame = 1'b1;
        end
      end
      default: begin
        state_next.phase = ecgdf_pkg::PH_SEEK;
        if (is_busy) begin
          state_next.phase = ecgdf_pkg::PH_BUSY;
        end else if (hdr_bit) begin
          state_next = hdr_state;
          result = hdr_result;
        end
      end
    endcase
  end

endmodule

`default_nettype wire
